>>> hdl/wsd_pkg.sv
// Package for the WebSocket frame deframer: phase and event codes,
// the result struct and sizing constants. No dependencies.

package wsd_pkg;

    localparam int LENGTH_BITS = 64;

    localparam logic [7:0] FLAG_MASK     = 8'h80;
    localparam logic [7:0] OPCODE_MASK   = 8'h0f;
    localparam logic [7:0] LEN_CODE_MASK = 8'h7f;
    localparam logic [6:0] LEN_CODE_16   = 7'd126;
    localparam logic [6:0] LEN_CODE_64   = 7'd127;
    localparam logic [1:0] POS_MASK      = 2'h3;

    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    localparam logic [2:0] EV_DATA      = 3'd0;
    localparam logic [2:0] EV_EMPTY_END = 3'd1;
    localparam logic [2:0] EV_PING      = 3'd2;
    localparam logic [2:0] EV_PONG      = 3'd3;
    localparam logic [2:0] EV_CLOSE     = 3'd4;
    localparam logic [2:0] EV_ERROR     = 3'd5;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_HALTED
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] ev;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       last;
    } result_t;

endpackage

>>> hdl/websocket_frame_deframer_core.sv
// WebSocket frame deframer, receive side: one stream byte per transaction.
// Input register, parser, result register; parser state updates in one pass.
// Throughput: one byte per cycle unless out_ready stalls a held result.
// Reset: rst_n clears the parser to await a first header byte and empties
// both the input and result registers. Close or error halts until reset.

module websocket_frame_deframer_core
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_res,
    output logic [7:0] data_byte,
    output logic [3:0] frame_opcode,
    output logic       message_last
);

    logic       advance;
    logic       held_valid;
    logic [7:0] held_byte;
    result_t    res;

    assign advance = held_valid && (!out_valid || out_ready);

    wsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    wsd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cur_byte (held_byte),
        .res      (res)
    );

    wsd_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .data_byte    (data_byte),
        .frame_opcode (frame_opcode),
        .message_last (message_last)
    );

endmodule

>>> hdl/wsd_in_stage.sv
// Input register of the deframer: holds one received byte until the
// parser consumes it. Depends on wsd_pkg.

module wsd_in_stage
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

>>> hdl/wsd_parser.sv
// Frame parser: header decode, length and mask key capture, payload
// unmasking and frame-end events. Depends on wsd_pkg.

module wsd_parser
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] cur_byte,
    output result_t    res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic        fin_reg;
    logic        fin_next;
    logic [3:0]  opcode_reg;
    logic [3:0]  opcode_next;
    logic        mask_reg;
    logic        mask_next;
    logic        long_reg;
    logic        long_next;
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;

    logic        hdr_done;
    logic        frame_end;
    logic [63:0] len_d;
    logic [3:0]  cnt_inc;
    logic [3:0]  need;
    logic [7:0]  key_byte;
    logic        rem_last;
    logic        is_data;
    logic        too_big;

    assign cnt_inc  = cnt_reg + 4'd1;
    assign need     = long_reg ? EXT_BYTES_64 : EXT_BYTES_16;
    assign key_byte = key_reg[(5'd24 - {pos_reg & POS_MASK, 3'b000}) +: 8];
    assign rem_last = (len_reg == 64'd1);
    assign is_data  = (opcode_reg <= OP_BINARY);
    assign too_big  = |(len_d >> LENGTH_BITS);

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        long_next   = long_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        hdr_done    = 1'b0;
        frame_end   = 1'b0;
        len_d       = len_reg;
        res.valid   = 1'b0;
        res.ev      = EV_DATA;
        res.data    = 8'h00;
        res.opcode  = opcode_reg;
        res.last    = 1'b0;

        case (phase_reg)
            PH_HDR0:
            begin
                fin_next    = |(cur_byte & FLAG_MASK);
                opcode_next = cur_byte[3:0] & OPCODE_MASK[3:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                mask_next = |(cur_byte & FLAG_MASK);
                long_next = ((cur_byte[6:0] & LEN_CODE_MASK[6:0]) == LEN_CODE_64);
                key_next  = 32'h0;
                cnt_next  = 4'd0;
                if ((cur_byte[6:0] & LEN_CODE_MASK[6:0]) >= LEN_CODE_16)
                begin
                    len_next   = 64'd0;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    len_d    = {57'd0, cur_byte[6:0]};
                    len_next = len_d;
                    if (mask_next)
                    begin
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_EXTLEN:
            begin
                len_d    = {len_reg[55:0], cur_byte};
                len_next = len_d;
                cnt_next = cnt_inc;
                if (cnt_inc >= need)
                begin
                    cnt_next = 4'd0;
                    if (mask_reg)
                    begin
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_MASK:
            begin
                key_next = {key_reg[23:0], cur_byte};
                cnt_next = cnt_inc;
                if (cnt_inc == KEY_BYTES)
                begin
                    cnt_next = 4'd0;
                    hdr_done = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                len_next = len_reg - 64'd1;
                pos_next = pos_reg + 2'd1;
                if (is_data)
                begin
                    if (rem_last)
                    begin
                        phase_next = PH_HDR0;
                    end
                    res.valid = 1'b1;
                    res.ev    = EV_DATA;
                    res.data  = cur_byte ^ key_byte;
                    res.last  = rem_last && fin_reg;
                end
                else if (rem_last)
                begin
                    frame_end = 1'b1;
                end
            end
            PH_HALTED:
            begin
                phase_next = PH_HALTED;
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase

        if (hdr_done)
        begin
            if (too_big)
            begin
                phase_next = PH_HALTED;
                res.valid  = 1'b1;
                res.ev     = EV_ERROR;
                res.last   = 1'b0;
            end
            else
            begin
                len_next = len_d;
                pos_next = 2'd0;
                if (len_d == 64'd0)
                begin
                    frame_end = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
        end

        if (frame_end)
        begin
            phase_next = PH_HDR0;
            if (is_data)
            begin
                if (fin_reg)
                begin
                    res.valid = 1'b1;
                    res.ev    = EV_EMPTY_END;
                    res.last  = 1'b1;
                end
            end
            else if (opcode_reg == OP_PING)
            begin
                res.valid = 1'b1;
                res.ev    = EV_PING;
                res.last  = 1'b1;
            end
            else if (opcode_reg == OP_PONG)
            begin
                res.valid = 1'b1;
                res.ev    = EV_PONG;
                res.last  = 1'b1;
            end
            else
            begin
                phase_next = PH_HALTED;
                res.valid  = 1'b1;
                res.ev     = (opcode_reg == OP_CLOSE) ? EV_CLOSE : EV_ERROR;
                res.last   = 1'b0;
            end
        end

        if (!advance)
        begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            cnt_reg    <= 4'd0;
            fin_reg    <= 1'b0;
            opcode_reg <= 4'd0;
            mask_reg   <= 1'b0;
            long_reg   <= 1'b0;
            len_reg    <= 64'd0;
            key_reg    <= 32'h0;
            pos_reg    <= 2'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            long_reg   <= long_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

>>> hdl/wsd_out_reg.sv
// Result register of the deframer: holds one result until the
// downstream side takes it. Depends on wsd_pkg.

module wsd_out_reg
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  result_t    res,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_res,
    output logic [7:0] data_byte,
    output logic [3:0] frame_opcode,
    output logic       message_last
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign out_valid    = valid_reg;
    assign event_res    = data_reg.ev;
    assign data_byte    = data_reg.data;
    assign frame_opcode = data_reg.opcode;
    assign message_last = data_reg.last;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            data_reg <= res;
        end
    end

endmodule

>>> hdl/wsd_checker.sv
// Port-level checks for the deframer top level, attached by bind.
// Depends on wsd_pkg and websocket_frame_deframer_core.

module wsd_checker
    import wsd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_res,
    input logic [7:0] data_byte,
    input logic [3:0] frame_opcode,
    input logic       message_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(data_byte) && $stable(frame_opcode) && $stable(message_last))
        else $error("result changed while stalled");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res <= EV_ERROR)
        else $error("event code out of range");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_DATA |-> data_byte == 8'h00)
        else $error("data byte set on a non-data event");

    a_halt_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_CLOSE || event_res == EV_ERROR) |-> !message_last)
        else $error("message end flagged on close or error");

    a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_EMPTY_END || event_res == EV_PING
            || event_res == EV_PONG) |-> message_last)
        else $error("message end missing on frame-end event");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (.*);
